FILE: rtl/core/csvfs_pkg.sv
// shared types and character codes for the csv field splitter
package csvfs_pkg;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } csvfs_in_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic       field_empty;
    logic       end_of_input;
  } csvfs_out_t;

  // results caused by one input byte, in issue order: data or field end, then final end
  typedef struct packed {
    logic       data_vld;
    logic       end_vld;
    logic       end_empty;
    logic       fin_vld;
    logic       fin_empty;
    logic [7:0] data_byte;
  } csvfs_cmd_t;

endpackage

FILE: rtl/core/csvfs_front.sv
// front part: parser state and per-byte classification into result commands
module csvfs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  csvfs_pkg::csvfs_in_t  in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output csvfs_pkg::csvfs_cmd_t q_cmd
);
  import csvfs_pkg::*;

  logic at_field_start, quoted_field, quotes_closed;
  logic trail_byte_due, skip_linefeed, field_has_data;
  logic at_field_start_next, quoted_field_next, quotes_closed_next;
  logic trail_byte_due_next, skip_linefeed_next, field_has_data_next;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    logic [7:0] b;
    logic       term;
    logic       closed_now;
    b          = in_data.in_byte;
    term       = (b == CH_COMMA) || (b == CH_CR) || (b == CH_LF);
    closed_now = quotes_closed ^ (quoted_field && (b == CH_QUOTE));

    at_field_start_next = at_field_start;
    quoted_field_next   = quoted_field;
    quotes_closed_next  = quotes_closed;
    trail_byte_due_next = trail_byte_due;
    skip_linefeed_next  = skip_linefeed;
    field_has_data_next = field_has_data;
    q_cmd               = '0;
    q_cmd.data_byte     = b;

    if (trail_byte_due) begin
      trail_byte_due_next = 1'b0;
      q_cmd.data_vld      = 1'b1;
      field_has_data_next = 1'b1;
    end else begin
      skip_linefeed_next = 1'b0;
      if (skip_linefeed && (b == CH_LF)) begin
        // lone lf after a terminator is dropped
      end else if (at_field_start && (b == CH_QUOTE)) begin
        at_field_start_next = 1'b0;
        quoted_field_next   = 1'b1;
        quotes_closed_next  = 1'b0;
      end else begin
        at_field_start_next = 1'b0;
        if (b[7]) begin
          trail_byte_due_next = 1'b1;
          q_cmd.data_vld      = 1'b1;
          field_has_data_next = 1'b1;
        end else begin
          quotes_closed_next = closed_now;
          if ((!quoted_field || closed_now) && term) begin
            q_cmd.end_vld       = 1'b1;
            q_cmd.end_empty     = !field_has_data;
            at_field_start_next = 1'b1;
            quoted_field_next   = 1'b0;
            quotes_closed_next  = 1'b0;
            field_has_data_next = 1'b0;
            skip_linefeed_next  = 1'b1;
          end else if (!closed_now) begin
            q_cmd.data_vld      = 1'b1;
            field_has_data_next = 1'b1;
          end
        end
      end
    end

    if (in_data.last_byte) begin
      q_cmd.fin_vld       = 1'b1;
      q_cmd.fin_empty     = !field_has_data_next;
      at_field_start_next = 1'b1;
      quoted_field_next   = 1'b0;
      quotes_closed_next  = 1'b0;
      trail_byte_due_next = 1'b0;
      skip_linefeed_next  = 1'b0;
      field_has_data_next = 1'b0;
    end
  end

  assign q_push = accept && (q_cmd.data_vld || q_cmd.end_vld || q_cmd.fin_vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_field_start <= 1'b1;
      quoted_field   <= 1'b0;
      quotes_closed  <= 1'b0;
      trail_byte_due <= 1'b0;
      skip_linefeed  <= 1'b0;
      field_has_data <= 1'b0;
    end else if (accept) begin
      at_field_start <= at_field_start_next;
      quoted_field   <= quoted_field_next;
      quotes_closed  <= quotes_closed_next;
      trail_byte_due <= trail_byte_due_next;
      skip_linefeed  <= skip_linefeed_next;
      field_has_data <= field_has_data_next;
    end
  end

endmodule

FILE: rtl/core/csvfs_queue.sv
// command queue between front and back parts
module csvfs_queue #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  csvfs_pkg::csvfs_cmd_t push_cmd,
  input  logic                  pop,
  output csvfs_pkg::csvfs_cmd_t head_cmd,
  output logic                  empty,
  output logic                  full
);
  import csvfs_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  csvfs_cmd_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign empty    = (count == '0);
  assign full     = (count == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/csvfs_back.sv
// back part: unpacks commands into single results behind an output register
module csvfs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  csvfs_pkg::csvfs_cmd_t head_cmd,
  input  logic                  q_empty,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output csvfs_pkg::csvfs_out_t out_data
);
  import csvfs_pkg::*;

  csvfs_cmd_t cur, cur_next;
  csvfs_out_t res, out_reg;
  logic       out_vld, out_vld_next;
  logic       cur_busy, out_free;

  assign cur_busy = cur.data_vld || cur.end_vld || cur.fin_vld;
  assign out_free = !out_vld || out_ready;

  always_comb begin
    csvfs_cmd_t after;
    after = cur;
    res   = '0;
    if (cur.data_vld) begin
      res.result_kind = KIND_DATA;
      res.data_byte   = cur.data_byte;
      after.data_vld  = 1'b0;
    end else if (cur.end_vld) begin
      res.result_kind = KIND_END;
      res.field_empty = cur.end_empty;
      after.end_vld   = 1'b0;
    end else begin
      res.result_kind  = KIND_END;
      res.field_empty  = cur.fin_empty;
      res.end_of_input = 1'b1;
      after.fin_vld    = 1'b0;
    end
    if (!(out_free && cur_busy)) begin
      after = cur;
    end

    // refill as soon as the held command has nothing left to issue
    q_pop    = !(after.data_vld || after.end_vld || after.fin_vld) && !q_empty;
    cur_next = q_pop ? head_cmd : after;
    out_vld_next = out_free ? cur_busy : out_vld;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.data_vld <= 1'b0;
      cur.end_vld  <= 1'b0;
      cur.fin_vld  <= 1'b0;
      out_vld      <= 1'b0;
    end else begin
      cur.data_vld <= cur_next.data_vld;
      cur.end_vld  <= cur_next.end_vld;
      cur.fin_vld  <= cur_next.fin_vld;
      out_vld      <= out_vld_next;
    end
    cur.end_empty <= cur_next.end_empty;
    cur.fin_empty <= cur_next.fin_empty;
    cur.data_byte <= cur_next.data_byte;
    if (out_free && cur_busy) begin
      out_reg <= res;
    end
  end

  assign out_valid = out_vld;
  assign out_data  = out_reg;

endmodule

FILE: rtl/core/csv_field_splitter_unit.sv
// top level of the csv field splitter: front, command queue and back part
// results pass the queue entry, the held command and the output register
// throughput: one byte per cycle unless the queue is full; results leave
// at one per cycle while out_ready, so two-result bytes take queue slack
// reset: parser flags return to the start of a stream, queue and output empty
module csv_field_splitter_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csvfs_pkg::csvfs_in_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csvfs_pkg::csvfs_out_t out_data
);
  import csvfs_pkg::*;

  csvfs_cmd_t push_cmd, head_cmd;
  logic       q_push, q_pop, q_empty, q_full;

  csvfs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  csvfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  csvfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/csvfs_checker.sv
// port-level checker for the csv field splitter, bound to the top level
module csvfs_assert (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input csvfs_pkg::csvfs_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input csvfs_pkg::csvfs_out_t out_data
);
  import csvfs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // data results carry no end flags
  a_data_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == KIND_DATA) |->
      !out_data.field_empty && !out_data.end_of_input)
    else $error("end flags set on a data result");

  // field end markers carry a zero byte
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.result_kind == KIND_END) |-> (out_data.data_byte == 8'h00))
    else $error("nonzero byte on a field end");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind csv_field_splitter_unit csvfs_assert u_csvfs_assert (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
